// ===== hdl/swpt_pkg.sv =====
// Shared types and codes for the spray-and-wait packet table.
`timescale 1ns / 1ps
package swpt_pkg;

    typedef enum logic [1:0] {
        ACT_LOOKUP   = 2'd0,
        ACT_ENQUEUE  = 2'd1,
        ACT_DISCOUNT = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_DUPLICATE  = 3'd1,
        ST_EVICTED    = 3'd2,
        ST_FOUND      = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_DISCOUNTED = 3'd5,
        ST_REFUSED    = 3'd6
    } t_status;

    localparam logic [0:0] REG_BINARY_MODE = 1'd0;
    localparam logic [0:0] REG_MAX_ENTRIES = 1'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] packet_key;
        logic [15:0] initial_replicas;
        logic [31:0] expiry_time;
        logic [31:0] now_time;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] replicas_forward;
        logic [15:0] replicas_left;
        logic [31:0] entry_expiry;
        logic [31:0] evicted_key;
        logic [31:0] drop_total;
    } t_rsp;

    // One table entry as held in the slot memory.
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] replicas;
        logic [31:0] expiry;
    } t_slot;

endpackage

// ===== hdl/spray_wait_packet_table_core.sv =====
// Spray-and-wait packet table: one request at a time, one response per request.
// Lookups, enqueues and discounts sweep the slot memory once, one slot per cycle
// through its single registered read port. The sweep purges expired entries (not
// for a discount) while it looks for the key, a free slot and the entry that
// expires earliest. S_DECIDE then decides, writes back and loads the response
// register, and S_RESP raises the output valid. The unused action code ACT_NONE
// skips the sweep and is answered as refused from S_RESP. The next request is
// taken the cycle after the response has been collected.
`timescale 1ns / 1ps
module spray_wait_packet_table_core
    import swpt_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rsp        o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RESP
    } t_state;

    t_state        r_state;
    t_req          r_req;
    logic          r_binary;
    logic [7:0]    r_max;
    logic [CAPACITY-1:0] r_valid;
    logic [CW-1:0] r_count;
    logic [31:0]   r_drops;

    logic [AW:0]   r_idx;      // address issued
    logic          r_rd_v;     // read data of r_rd_a arrives this cycle
    logic [AW-1:0] r_rd_a;
    logic          r_hit;
    logic [AW-1:0] r_hit_a;
    t_slot         r_hit_d;
    logic          r_free;
    logic [AW-1:0] r_free_a;
    logic          r_best;
    logic [AW-1:0] r_best_a;
    t_slot         r_best_d;
    t_rsp          r_rsp;
    t_rsp          n_rsp;
    logic          r_ovalid;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_slot         mem_wd;
    t_slot         rd;

    swpt_slot_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_wa),
        .i_wdata(mem_wd),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(rd)
    );

    // Effective capacity.
    logic [CW-1:0] cap;
    always_comb begin
        if (r_max == 8'd0) begin
            cap = CW'(1);
        end else if (32'(r_max) > CAPACITY) begin
            cap = CW'(CAPACITY);
        end else begin
            cap = CW'(r_max);
        end
    end

    logic purging;
    assign purging = (r_req.action != ACT_DISCOUNT);

    logic slot_live, slot_expired;
    assign slot_live    = r_rd_v && r_valid[r_rd_a];
    assign slot_expired = purging && (rd.expiry <= r_req.now_time);

    logic better;
    assign better = !r_best || (rd.expiry < r_best_d.expiry) ||
                    (rd.expiry == r_best_d.expiry && rd.key < r_best_d.key);

    logic [15:0] fwd;
    assign fwd = r_binary ? {1'b0, r_hit_d.replicas[15:1]} : 16'd1;

    logic full;
    assign full = (r_count >= cap);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_hit_a;
        mem_wd = r_hit_d;
        if (r_state == S_DECIDE) begin
            priority if (r_req.action == ACT_DISCOUNT) begin
                mem_we = r_hit && (r_hit_d.replicas > 16'd1);
                mem_wd.replicas = r_hit_d.replicas - fwd;
            end else if (r_req.action == ACT_ENQUEUE && !r_hit) begin
                mem_we = 1'b1;
                mem_wa = (full || !r_free) ? r_best_a : r_free_a;
                mem_wd = '{key: r_req.packet_key, replicas: r_req.initial_replicas,
                           expiry: r_req.expiry_time};
            end else begin
                mem_we = 1'b0;
            end
        end
    end

    // Response of a swept request, loaded in S_DECIDE.
    always_comb begin
        n_rsp            = '0;
        n_rsp.status     = ST_REFUSED;
        n_rsp.drop_total = r_drops;
        priority if (r_req.action == ACT_LOOKUP) begin
            n_rsp.status = r_hit ? ST_FOUND : ST_NOT_FOUND;
            if (r_hit) begin
                n_rsp.replicas_left = r_hit_d.replicas;
                n_rsp.entry_expiry  = r_hit_d.expiry;
            end
        end else if (r_req.action == ACT_ENQUEUE) begin
            if (r_hit) begin
                n_rsp.status        = ST_DUPLICATE;
                n_rsp.replicas_left = r_hit_d.replicas;
                n_rsp.entry_expiry  = r_hit_d.expiry;
            end else begin
                n_rsp.status        = full ? ST_EVICTED : ST_INSERTED;
                n_rsp.replicas_left = r_req.initial_replicas;
                n_rsp.entry_expiry  = r_req.expiry_time;
                if (full) begin
                    if (r_drops != '1) begin
                        n_rsp.drop_total = r_drops + 32'd1;
                    end
                    n_rsp.evicted_key = r_best ? r_best_d.key : 32'd0;
                end
            end
        end else begin
            if (r_hit) begin
                n_rsp.entry_expiry  = r_hit_d.expiry;
                n_rsp.replicas_left = r_hit_d.replicas;
                if (r_hit_d.replicas > 16'd1) begin
                    n_rsp.status           = ST_DISCOUNTED;
                    n_rsp.replicas_forward = fwd;
                    n_rsp.replicas_left    = r_hit_d.replicas - fwd;
                end
            end
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_binary <= 1'b0;
            r_max    <= 8'd128;
            r_valid  <= '0;
            r_count  <= '0;
            r_drops  <= '0;
            r_ovalid <= 1'b0;
            r_rd_v   <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BINARY_MODE: r_binary <= i_cfg_data[0];
                    REG_MAX_ENTRIES: r_max    <= i_cfg_data;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req  <= i_req;
                        r_idx  <= '0;
                        r_rd_v <= 1'b0;
                        r_hit  <= 1'b0;
                        r_free <= 1'b0;
                        r_best <= 1'b0;
                        r_state <= (t_action'(i_req.action) == ACT_NONE) ? S_RESP : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Issue the next address, examine the slot read last cycle.
                    r_rd_v <= (r_idx < (AW+1)'(CAPACITY));
                    r_rd_a <= r_idx[AW-1:0];
                    if (r_idx < (AW+1)'(CAPACITY)) begin
                        r_idx <= r_idx + (AW+1)'(1);
                    end
                    if (r_rd_v && !r_valid[r_rd_a] && !r_free) begin
                        r_free   <= 1'b1;
                        r_free_a <= r_rd_a;
                    end
                    if (slot_live) begin
                        if (slot_expired) begin
                            r_valid[r_rd_a] <= 1'b0;
                            r_count <= r_count - CW'(1);
                            if (!r_free) begin
                                r_free   <= 1'b1;
                                r_free_a <= r_rd_a;
                            end
                        end else begin
                            if (rd.key == r_req.packet_key && !r_hit) begin
                                r_hit   <= 1'b1;
                                r_hit_a <= r_rd_a;
                                r_hit_d <= rd;
                            end
                            if (better) begin
                                r_best   <= 1'b1;
                                r_best_a <= r_rd_a;
                                r_best_d <= rd;
                            end
                        end
                    end
                    if (!r_rd_v && r_idx == (AW+1)'(CAPACITY)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_rsp   <= n_rsp;
                    r_drops <= n_rsp.drop_total;
                    r_state <= S_RESP;
                    if (r_req.action == ACT_ENQUEUE && !r_hit) begin
                        // Evicted slot is reused; count is unchanged.
                        if (full && r_best) begin
                            r_valid[r_best_a] <= 1'b1;
                        end else if (r_free) begin
                            r_valid[r_free_a] <= 1'b1;
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_RESP: begin
                    if (r_req.action == ACT_NONE) begin
                        r_rsp <= '{status: ST_REFUSED, replicas_forward: 16'd0,
                                   replicas_left: 16'd0, entry_expiry: 32'd0,
                                   evicted_key: 32'd0, drop_total: r_drops};
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/swpt_slot_mem.sv =====
// Slot memory: one write port and one registered read port.
`timescale 1ns / 1ps
module swpt_slot_mem
    import swpt_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/swpt_checker.sv =====
// Port-level checks for the packet table, bound to the top level.
`timescale 1ns / 1ps
module swpt_port_checks
    import swpt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken while response pending");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status <= ST_REFUSED)
        else $error("bad status");

    a_one_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("response without work");

endmodule

bind spray_wait_packet_table_core swpt_port_checks u_swpt_port_checks (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_rsp  (o_rsp)
);
